// ===== src/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: the block
// table entry, the scan packet that walks the cell chain, and the command
// word broadcast by the controller.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 12;
    localparam logic [15:0] HEAP_SIZE_RESET = 16'd32768;

    // request codes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // result codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    // one block table entry
    typedef struct packed {
        logic        valid;
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
    } entry_t;

    // scan packet handed from cell to cell
    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [15:0] key;        // request bytes or payload offset
        logic        found;
        logic        split;
        logic [15:0] offset;
        logic        last_free;  // previous cell holds a free block
        logic        prev_free;  // block before the hit is free
        logic        next_free;  // block after the hit is free
        logic        hit_prev;   // hit was in the previous cell
    } pkt_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        init;
        logic [15:0] init_size;
        logic        alloc;
        logic        split;
        logic [15:0] req;
        logic        free_mark;
        logic        merge_next;
        logic        merge_prev;
    } cmd_t;

    // payload of the first block for a given heap size, saturated at zero
    function automatic logic [15:0] first_payload(input logic [15:0] heap,
                                                  input logic [15:0] hdr);
        logic [15:0] res;
        begin
            res = (heap >= hdr) ? (heap - hdr) : 16'd0;
            return res;
        end
    endfunction

endpackage

// ===== src/ffha_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_cell
// One table slot. Checks the passing scan packet against its own block,
// remembers whether it was the hit or lies after it, and applies split,
// insert, merge and remove commands with data from its neighbors.
// ----------------------------------------------------------------------------
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter bit HEAD         = 1'b0
) (
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  pkt_t   pkt_in,
    output pkt_t   pkt_out,
    input  entry_t prev_entry,
    input  logic   prev_hit,
    input  entry_t next_entry,
    input  logic   next_hit,
    output entry_t entry,
    output logic   hit
);

    localparam logic [15:0] HDR = 16'(HEADER_BYTES);

    entry_t entry_reg, entry_next;
    logic   hit_reg, after_reg;
    pkt_t   pkt_reg, pkt_next;

    logic        is_hit;
    logic [16:0] hdr_off;
    logic [16:0] need;

    assign entry   = entry_reg;
    assign hit     = hit_reg;
    assign pkt_out = pkt_reg;

    // scan check of this block
    always_comb
    begin
        hdr_off = {1'b0, entry_reg.start} + {1'b0, HDR};
        need    = {1'b0, pkt_in.key} + {1'b0, HDR};
        is_hit  = 1'b0;
        if (pkt_in.valid && !pkt_in.found && entry_reg.valid)
        begin
            if (pkt_in.op == OP_ALLOC)
                is_hit = entry_reg.free && (entry_reg.size >= pkt_in.key);
            else
                is_hit = !entry_reg.free && (hdr_off == {1'b0, pkt_in.key});
        end
        pkt_next           = pkt_in;
        pkt_next.hit_prev  = 1'b0;
        pkt_next.last_free = entry_reg.valid && entry_reg.free;
        if (pkt_in.hit_prev)
            pkt_next.next_free = entry_reg.valid && entry_reg.free;
        if (is_hit)
        begin
            pkt_next.found     = 1'b1;
            pkt_next.split     = {1'b0, entry_reg.size} > need;
            pkt_next.offset    = hdr_off[15:0];
            pkt_next.prev_free = pkt_in.last_free;
            pkt_next.hit_prev  = 1'b1;
        end
    end

    // table update
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.init)
        begin
            entry_next.valid = HEAD;
            entry_next.start = 16'd0;
            entry_next.size  = cmd.init_size;
            entry_next.free  = 1'b1;
        end
        else if (cmd.alloc)
        begin
            if (hit_reg)
            begin
                entry_next.free = 1'b0;
                if (cmd.split)
                    entry_next.size = cmd.req;
            end
            else if (cmd.split && prev_hit)
            begin
                entry_next.valid = 1'b1;
                entry_next.start = prev_entry.start + cmd.req + HDR;
                entry_next.size  = prev_entry.size - cmd.req - HDR;
                entry_next.free  = 1'b1;
            end
            else if (cmd.split && after_reg)
                entry_next = prev_entry;
        end
        else if (cmd.free_mark)
        begin
            if (hit_reg)
            begin
                entry_next.free = 1'b1;
                if (cmd.merge_next)
                    entry_next.size = entry_reg.size + HDR + next_entry.size;
            end
            else if (cmd.merge_next && after_reg)
                entry_next = next_entry;
        end
        else if (cmd.merge_prev)
        begin
            if (next_hit)
                entry_next.size = entry_reg.size + HDR + next_entry.size;
            else if (hit_reg || after_reg)
                entry_next = next_entry;
        end
    end

    // slot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= HEAD;
            entry_reg.start <= 16'd0;
            entry_reg.size  <= first_payload(HEAP_SIZE_RESET, HDR);
            entry_reg.free  <= 1'b1;
            hit_reg         <= 1'b0;
            after_reg       <= 1'b0;
            pkt_reg         <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            pkt_reg   <= pkt_next;
            if (pkt_in.valid)
            begin
                hit_reg   <= is_hit;
                after_reg <= pkt_in.found;
            end
        end
    end

endmodule

// ===== src/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: launches the scan packet, reads it back at the end of
// the chain, issues the table commands, keeps the block count and the heap
// size register, and holds the result item.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] req_size,
    input  logic [15:0] payload_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] result_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output pkt_t        pkt_launch,
    input  pkt_t        pkt_exit,
    output cmd_t        cmd
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [15:0] HDR = 16'(HEADER_BYTES);
    localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_MERGE = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   heap_reg, heap_next;
    logic [15:0]   req_reg, req_next;
    status_t       res_st_reg, res_st_next;
    logic [15:0]   res_off_reg, res_off_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_st_reg, out_st_next;
    logic [15:0]   out_off_reg, out_off_next;
    logic          in_fire, cfg_fire;

    assign in_ready      = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign result_offset = out_off_reg;

    // scan packet launch
    always_comb
    begin
        pkt_launch       = '0;
        pkt_launch.valid = in_fire;
        pkt_launch.op    = op_t'(opcode);
        pkt_launch.key   = (opcode == OP_ALLOC) ? req_size : payload_offset;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        heap_next      = heap_reg;
        req_next       = req_reg;
        res_st_next    = res_st_reg;
        res_off_next   = res_off_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_off_next   = out_off_reg;
        cmd            = '0;
        cmd.init_size  = first_payload(heap_next, HDR);
        cmd.req        = req_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    heap_next     = cfg_data;
                    cmd.init      = 1'b1;
                    cmd.init_size = first_payload(cfg_data, HDR);
                    count_next    = CW'(1);
                end
                else if (in_fire)
                begin
                    req_next   = req_size;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pkt_exit.valid)
                begin
                    res_st_next  = ST_OK;
                    res_off_next = 16'd0;
                    state_next   = S_RESP;
                    if (pkt_exit.op == OP_ALLOC)
                    begin
                        if (!pkt_exit.found || (pkt_exit.split && count_reg == FULL))
                            res_st_next = ST_NO_FIT;
                        else
                        begin
                            cmd.alloc    = 1'b1;
                            cmd.split    = pkt_exit.split;
                            res_off_next = pkt_exit.offset;
                            if (pkt_exit.split)
                                count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (!pkt_exit.found)
                            res_st_next = ST_BAD_FREE;
                        else
                        begin
                            cmd.free_mark  = 1'b1;
                            cmd.merge_next = pkt_exit.next_free;
                            if (pkt_exit.next_free)
                                count_next = count_reg - CW'(1);
                            if (pkt_exit.prev_free)
                                state_next = S_MERGE;
                        end
                    end
                end
            end
            S_MERGE:
            begin
                cmd.merge_prev = 1'b1;
                count_next     = count_reg - CW'(1);
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_off_next   = res_off_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            heap_reg      <= HEAP_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            heap_reg      <= heap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_st_reg  <= res_st_next;
        res_off_reg <= res_off_next;
        out_st_reg  <= out_st_next;
        out_off_reg <= out_off_next;
    end

endmodule

// ===== src/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with splitting and coalescing of free blocks,
// built as a chain of table cells walked by a scan packet.
// ----------------------------------------------------------------------------
// For each request the scan packet moves one cell per cycle down the chain of
// MAX_BLOCKS cells; then the table is updated (split and insert, or mark and
// merge with the next block), a free with a free left neighbor takes a further
// merge step with the block before it, and the result register is loaded once
// it is empty or its result is being taken.
// One item is worked on at a time; the next is taken once the result is in
// the output register, even if it has not been taken yet. A configuration
// write of the heap size resets the table to one free block.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] req_size,
    input  logic [15:0] payload_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] result_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cmd_t   cmd;
    pkt_t   pkt_chain [MAX_BLOCKS+1];
    entry_t entries   [MAX_BLOCKS];
    logic   hits      [MAX_BLOCKS];

    // sequencer
    ffha_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .req_size       (req_size),
        .payload_offset (payload_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_offset  (result_offset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .pkt_launch     (pkt_chain[0]),
        .pkt_exit       (pkt_chain[MAX_BLOCKS]),
        .cmd            (cmd)
    );

    // chain of table cells
    genvar k;
    generate
        for (k = 0; k < MAX_BLOCKS; k++)
        begin : g_cell
            entry_t prev_e, next_e;
            logic   prev_h, next_h;

            if (k == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_h = 1'b0;
            end
            else
            begin : g_mid_prev
                assign prev_e = entries[k-1];
                assign prev_h = hits[k-1];
            end

            if (k == MAX_BLOCKS - 1)
            begin : g_last
                assign next_e = '0;
                assign next_h = 1'b0;
            end
            else
            begin : g_mid_next
                assign next_e = entries[k+1];
                assign next_h = hits[k+1];
            end

            ffha_cell #(
                .HEADER_BYTES (HEADER_BYTES),
                .HEAD         (k == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .pkt_in     (pkt_chain[k]),
                .pkt_out    (pkt_chain[k+1]),
                .prev_entry (prev_e),
                .prev_hit   (prev_h),
                .next_entry (next_e),
                .next_hit   (next_h),
                .entry      (entries[k]),
                .hit        (hits[k])
            );
        end
    endgenerate

endmodule
